[rtl/core/ifs_fern_pkg.sv]
// Shared types, map coefficients and pixel scaling constants for the fern point plotter.
package ifs_fern_pkg;

	localparam logic OP_ITERATE = 1'b0;
	localparam logic OP_READ    = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [6:0] random_pick;
		logic [7:0] read_row;
		logic [6:0] read_col;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0] map_chosen;
		logic [7:0] plot_row;
		logic [6:0] plot_col;
		logic       plotted;
		logic       pixel_bit;
	} rsp_item_t;

	typedef logic [1:0] map_idx_t;

	localparam map_idx_t MAP_STEM  = 2'd0;
	localparam map_idx_t MAP_LEFT  = 2'd1;
	localparam map_idx_t MAP_RIGHT = 2'd2;
	localparam map_idx_t MAP_MAIN  = 2'd3;

	typedef struct packed {
		logic     valid;
		logic     is_read;
		logic     rd_hit;
		map_idx_t map;
	} stage_ctl_t;

	localparam int POINT_W   = 24;
	localparam int FRAC_BITS = 18;
	typedef logic signed [POINT_W-1:0] point_t;

	localparam int COEF_W = 20;
	typedef logic signed [COEF_W-1:0] coef_t;

	localparam logic [6:0] CUM_STEM  = 7'd1;
	localparam logic [6:0] CUM_LEFT  = 7'd8;
	localparam logic [6:0] CUM_RIGHT = 7'd15;

	// x' = a x + b y + c, y' = d x + e y + f, all Q.18
	localparam coef_t COEF_A [4] = '{20'sd0, 20'sd52429, -20'sd39322, 20'sd222822};
	localparam coef_t COEF_B [4] = '{20'sd0, -20'sd68157, 20'sd73400, 20'sd10486};
	localparam coef_t COEF_C [4] = '{20'sd0, 20'sd0, 20'sd0, 20'sd0};
	localparam coef_t COEF_D [4] = '{20'sd0, 20'sd60293, 20'sd68157, -20'sd10486};
	localparam coef_t COEF_E [4] = '{20'sd41943, 20'sd57672, 20'sd62915, 20'sd222822};
	localparam coef_t COEF_F [4] = '{20'sd0, 20'sd419430, 20'sd115343, 20'sd419430};

	// col = trunc(W * (x + 2.75) / 5.5), 5.5 in Q.18 is 11 << 17
	localparam int X_OFFSET     = 720896;
	localparam int COL_LIMIT    = 1441792;
	localparam int COL_SHIFT    = 17;
	localparam int COL_DIVISOR  = 11;
	localparam int COL_RECIP_SH = 20;
	localparam int COL_RECIP    = (1 << COL_RECIP_SH) / COL_DIVISOR;

	// row = trunc(H * (101 - 10 y) / 101), 101 in Q.18 is 101 << 18
	localparam int ROW_BASE     = 26476544;
	localparam int ROW_SCALE    = 10;
	localparam int ROW_SHIFT    = 18;
	localparam int ROW_DIVISOR  = 101;
	localparam int ROW_RECIP_SH = 24;
	localparam int ROW_RECIP    = (1 << ROW_RECIP_SH) / ROW_DIVISOR;

endpackage

[rtl/core/ifs_fern_ram.sv]
// Generic single-port RAM with registered read data.
module ifs_fern_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

[rtl/core/ifs_fern_point_step.sv]
// Map selection and affine update of the fed-back point, one iteration per cycle while the pipeline advances.
module ifs_fern_point_step
	import ifs_fern_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  stage_ctl_t ctl_s1,
	input  logic [6:0] pick_s1,
	output stage_ctl_t ctl_s2,
	output point_t     x_s2,
	output point_t     y_s2
);

	localparam point_t SAT_HI = {1'b0, {(POINT_W-1){1'b1}}};
	localparam point_t SAT_LO = {1'b1, {(POINT_W-1){1'b0}}};

	point_t   point_x_q;
	point_t   point_y_q;
	point_t   next_x;
	point_t   next_y;
	map_idx_t map_sel;
	logic     step;

	function automatic point_t affine(point_t p, point_t q, coef_t s, coef_t k, coef_t off);
		logic signed [43:0] acc;
		logic signed [26:0] r;
		acc = 44'(p) * 44'(s) + 44'(q) * 44'(k);
		r   = 27'((acc + 44'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS) + 27'(off);
		if (r > 27'(SAT_HI)) begin
			return SAT_HI;
		end else if (r < 27'(SAT_LO)) begin
			return SAT_LO;
		end
		return POINT_W'(r);
	endfunction

	always_comb begin
		if (pick_s1 < CUM_STEM) begin
			map_sel = MAP_STEM;
		end else if (pick_s1 < CUM_LEFT) begin
			map_sel = MAP_LEFT;
		end else if (pick_s1 < CUM_RIGHT) begin
			map_sel = MAP_RIGHT;
		end else begin
			map_sel = MAP_MAIN;
		end
		step   = adv && ctl_s1.valid && !ctl_s1.is_read;
		next_x = affine(point_x_q, point_y_q, COEF_A[map_sel], COEF_B[map_sel], COEF_C[map_sel]);
		next_y = affine(point_x_q, point_y_q, COEF_D[map_sel], COEF_E[map_sel], COEF_F[map_sel]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_x_q <= '0;
			point_y_q <= '0;
			ctl_s2    <= '0;
		end else if (adv) begin
			ctl_s2.valid   <= ctl_s1.valid;
			ctl_s2.is_read <= ctl_s1.is_read;
			ctl_s2.rd_hit  <= ctl_s1.rd_hit;
			ctl_s2.map     <= ctl_s1.is_read ? MAP_STEM : map_sel;
			if (step) begin
				point_x_q <= next_x;
				point_y_q <= next_y;
			end
		end
	end

	// the point register doubles as the stage-two copy of the newest point
	assign x_s2 = point_x_q;
	assign y_s2 = point_y_q;

	a_point_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(point_x_q) && $stable(point_y_q))
		else $error("point changed without an iterate transaction");

endmodule

[rtl/core/ifs_fern_pixel_scale.sv]
// Pixel scaling of the new point: plane test, pre-shift, reciprocal divide and correction.
module ifs_fern_pixel_scale
	import ifs_fern_pkg::*;
#(
	parameter int PLANE_WIDTH = 128,
	parameter int PLANE_HEIGHT = 150,
	localparam int CW = $clog2(PLANE_WIDTH),
	localparam int RW = $clog2(PLANE_HEIGHT)
) (
	input  logic          clk,
	input  logic          adv,
	input  point_t        x_s2,
	input  point_t        y_s2,
	output logic [CW-1:0] col_s5,
	output logic [RW-1:0] row_s5,
	output logic          on_plane_s5
);

	localparam int WB  = $clog2(PLANE_WIDTH + 1);
	localparam int HB  = $clog2(PLANE_HEIGHT + 1);
	localparam int TW  = POINT_W + 1;
	localparam int NW  = TW + WB + 1;
	localparam int SW  = POINT_W + 4;
	localparam int MW  = SW + HB + 1;
	localparam int VCW = $clog2(COL_DIVISOR * PLANE_WIDTH);
	localparam int VRW = $clog2(ROW_DIVISOR * PLANE_HEIGHT);
	localparam int PCW = VCW + COL_RECIP_SH;
	localparam int PRW = VRW + ROW_RECIP_SH;

	localparam logic signed [TW-1:0] X_OFF_T      = TW'(X_OFFSET);
	localparam logic signed [TW-1:0] COL_LIMIT_T  = TW'(COL_LIMIT);
	localparam logic signed [NW-1:0] WIDTH_N      = NW'(PLANE_WIDTH);
	localparam logic signed [NW-1:0] NEG_LIMIT_N  = NW'(-COL_LIMIT);
	localparam logic signed [SW-1:0] ROW_BASE_S   = SW'(ROW_BASE);
	localparam logic signed [SW-1:0] ROW_SCALE_S  = SW'(ROW_SCALE);
	localparam logic signed [MW-1:0] HEIGHT_M     = MW'(PLANE_HEIGHT);
	localparam logic signed [MW-1:0] NEG_BASE_M   = MW'(-ROW_BASE);

	logic signed [TW-1:0] t;
	logic signed [NW-1:0] n;
	logic signed [SW-1:0] s;
	logic signed [MW-1:0] m;
	logic                 col_on;
	logic                 row_on;
	logic [VCW-1:0]       vcol;
	logic [VRW-1:0]       vrow;

	logic [VCW-1:0]       vcol_s3;
	logic [VRW-1:0]       vrow_s3;
	logic                 on_s3;

	logic [PCW-1:0]       pcol;
	logic [PRW-1:0]       prow;
	logic [CW-1:0]        qcol;
	logic [RW-1:0]        qrow;

	logic [CW-1:0]        qcol_s4;
	logic [RW-1:0]        qrow_s4;
	logic [VCW-1:0]       vcol_s4;
	logic [VRW-1:0]       vrow_s4;
	logic                 on_s4;

	logic [VCW-1:0]       rcol;
	logic [VRW-1:0]       rrow;
	logic [CW-1:0]        col;
	logic [RW-1:0]        row;

	// trunc toward zero: a numerator just below zero still lands on pixel zero
	always_comb begin
		t      = TW'(x_s2) + X_OFF_T;
		n      = NW'(t) * WIDTH_N;
		s      = ROW_BASE_S - SW'(y_s2) * ROW_SCALE_S;
		m      = MW'(s) * HEIGHT_M;
		col_on = (t < COL_LIMIT_T) && (n > NEG_LIMIT_N);
		row_on = (s < ROW_BASE_S) && (m > NEG_BASE_M);
		vcol   = (col_on && (n > NW'(0))) ? VCW'(n >>> COL_SHIFT) : '0;
		vrow   = (row_on && (m > MW'(0))) ? VRW'(m >>> ROW_SHIFT) : '0;
	end

	always_comb begin
		pcol = PCW'(vcol_s3) * PCW'(COL_RECIP);
		prow = PRW'(vrow_s3) * PRW'(ROW_RECIP);
		qcol = CW'(pcol >> COL_RECIP_SH);
		qrow = RW'(prow >> ROW_RECIP_SH);
	end

	// estimate is low by at most one
	always_comb begin
		rcol = vcol_s4 - VCW'(qcol_s4) * VCW'(COL_DIVISOR);
		rrow = vrow_s4 - VRW'(qrow_s4) * VRW'(ROW_DIVISOR);
		col  = qcol_s4 + CW'(rcol >= VCW'(COL_DIVISOR));
		row  = qrow_s4 + RW'(rrow >= VRW'(ROW_DIVISOR));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vcol_s3     <= vcol;
			vrow_s3     <= vrow;
			on_s3       <= col_on && row_on;
			qcol_s4     <= qcol;
			qrow_s4     <= qrow;
			vcol_s4     <= vcol_s3;
			vrow_s4     <= vrow_s3;
			on_s4       <= on_s3;
			col_s5      <= col;
			row_s5      <= row;
			on_plane_s5 <= on_s4;
		end
	end

endmodule

[rtl/core/ifs_fern_point_plotter_unit.sv]
// Top level of the fern point plotter: command pipeline, bitmap port and response register.
//
// Takes one command transaction per clock unless cmd_stall is high and returns one response
// transaction for each, in order. The point update is a loop around the point register,
// so iterates can follow each other every cycle while the pipeline advances; pixel
// scaling runs over stages s3 to s5 after it, and the bitmap RAM is touched at one stage
// by both plots and reads, so a read always sees every earlier plot. Back-pressure on the
// response side freezes the whole pipeline. After reset the bitmap is cleared one pixel
// per cycle over all PLANE_WIDTH * PLANE_HEIGHT pixels, and cmd_stall stays high until
// that pass ends.
module ifs_fern_point_plotter_unit
	import ifs_fern_pkg::*;
#(
	parameter int PLANE_WIDTH = 128,
	parameter int PLANE_HEIGHT = 150
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_item_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	localparam int CW    = $clog2(PLANE_WIDTH);
	localparam int RW    = $clog2(PLANE_HEIGHT);
	localparam int DEPTH = PLANE_WIDTH * PLANE_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	logic          adv;
	logic          clearing_q;
	logic [AW-1:0] clr_cnt_q;

	logic          valid_s1;
	cmd_item_t     item_s1;
	stage_ctl_t    ctl_s1;
	logic          rd_hit_s1;
	logic [AW-1:0] raddr_s1;

	stage_ctl_t    ctl_s2;
	stage_ctl_t    ctl_s3;
	stage_ctl_t    ctl_s4;
	stage_ctl_t    ctl_s5;
	stage_ctl_t    ctl_s6;
	logic [AW-1:0] raddr_s2;
	logic [AW-1:0] raddr_s3;
	logic [AW-1:0] raddr_s4;
	logic [AW-1:0] raddr_s5;
	point_t        x_s2;
	point_t        y_s2;

	logic [CW-1:0] col_s5;
	logic [RW-1:0] row_s5;
	logic          on_plane_s5;
	logic          plotted_s5;
	logic [AW-1:0] addr_s5;

	logic [AW-1:0] addr_s6;
	logic [CW-1:0] col_s6;
	logic [RW-1:0] row_s6;
	logic          plotted_s6;

	logic          rsp_valid_q;
	rsp_item_t     rsp_q;
	logic          rd_bit_q;

	logic          ram_en;
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [0:0]    ram_wdata;
	logic [0:0]    ram_rdata;

	assign adv       = !(rsp_valid_q && rsp_stall);
	assign cmd_stall = clearing_q || !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			if (clr_cnt_q == LAST_ADDR) begin
				clearing_q <= 1'b0;
			end else begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= cmd_valid && !clearing_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= cmd;
		end
	end

	always_comb begin
		rd_hit_s1      = (32'(item_s1.read_row) < PLANE_HEIGHT) &&
		                 (32'(item_s1.read_col) < PLANE_WIDTH);
		raddr_s1       = AW'(item_s1.read_row) * AW'(PLANE_WIDTH) + AW'(item_s1.read_col);
		ctl_s1.valid   = valid_s1;
		ctl_s1.is_read = item_s1.operation == OP_READ;
		ctl_s1.rd_hit  = rd_hit_s1;
		ctl_s1.map     = MAP_STEM;
	end

	ifs_fern_point_step u_point_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_s1  (ctl_s1),
		.pick_s1 (item_s1.random_pick),
		.ctl_s2  (ctl_s2),
		.x_s2    (x_s2),
		.y_s2    (y_s2)
	);

	ifs_fern_pixel_scale #(
		.PLANE_WIDTH  (PLANE_WIDTH),
		.PLANE_HEIGHT (PLANE_HEIGHT)
	) u_pixel_scale (
		.clk         (clk),
		.adv         (adv),
		.x_s2        (x_s2),
		.y_s2        (y_s2),
		.col_s5      (col_s5),
		.row_s5      (row_s5),
		.on_plane_s5 (on_plane_s5)
	);

	always_comb begin
		plotted_s5 = ctl_s5.valid && !ctl_s5.is_read && on_plane_s5;
		addr_s5    = ctl_s5.is_read ? raddr_s5
		                            : AW'(row_s5) * AW'(PLANE_WIDTH) + AW'(col_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3     <= '0;
			ctl_s4     <= '0;
			ctl_s5     <= '0;
			ctl_s6     <= '0;
			plotted_s6 <= 1'b0;
		end else if (adv) begin
			ctl_s3     <= ctl_s2;
			ctl_s4     <= ctl_s3;
			ctl_s5     <= ctl_s4;
			ctl_s6     <= ctl_s5;
			plotted_s6 <= plotted_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			raddr_s2 <= raddr_s1;
			raddr_s3 <= raddr_s2;
			raddr_s4 <= raddr_s3;
			raddr_s5 <= raddr_s4;
			addr_s6  <= addr_s5;
			col_s6   <= col_s5;
			row_s6   <= row_s5;
		end
	end

	always_comb begin
		ram_en    = clearing_q ||
		            (adv && ctl_s6.valid && (plotted_s6 || (ctl_s6.is_read && ctl_s6.rd_hit)));
		ram_we    = clearing_q || plotted_s6;
		ram_addr  = clearing_q ? clr_cnt_q : addr_s6;
		ram_wdata = !clearing_q;
	end

	ifs_fern_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_bitmap (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= ctl_s6.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.map_chosen <= ctl_s6.map;
			rsp_q.plot_row   <= plotted_s6 ? 8'(row_s6) : '0;
			rsp_q.plot_col   <= plotted_s6 ? 7'(col_s6) : '0;
			rsp_q.plotted    <= plotted_s6;
			rsp_q.pixel_bit  <= 1'b0;
			rd_bit_q         <= ctl_s6.is_read && ctl_s6.rd_hit;
		end
	end

	// read data lands together with the response register and holds while stalled
	always_comb begin
		rsp           = rsp_q;
		rsp.pixel_bit = rd_bit_q && ram_rdata[0];
	end

	assign rsp_valid = rsp_valid_q;

	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !ctl_s6.valid && !rsp_valid_q)
		else $error("transaction in flight during bitmap clear");

	a_plot_in_plane: assert property (@(posedge clk) disable iff (!arst_n)
		plotted_s6 |-> (32'(row_s6) < PLANE_HEIGHT) && (32'(col_s6) < PLANE_WIDTH))
		else $error("plot address outside the plane");

	a_plot_not_read: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.plotted |-> !rd_bit_q)
		else $error("response marked as both plot and read");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> valid_s1)
		else $error("accepted transaction missing from first stage");

endmodule

[sim/fern_plot_tb_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard for the fern point plotter: point and bitmap prediction plus response checking.
package fern_plot_tb_pkg;
	import ifs_fern_pkg::*;

	localparam int PLANE_W = 128;
	localparam int PLANE_H = 150;

	class fern_plot_scoreboard;
		int coefs [4][6];
		longint pt_x;
		longint pt_y;
		bit plane_bits [PLANE_W * PLANE_H];
		rsp_item_t expected_rsp [$];
		int mismatches;
		int last_row;
		int last_col;

		function new();
			// a, b, c, d, e, f per map in Q.18
			coefs = '{
				'{0, 0, 0, 0, 41943, 0},
				'{52429, -68157, 0, 60293, 57672, 419430},
				'{-39322, 73400, 0, 68157, 62915, 115343},
				'{222822, 10486, 0, -10486, 222822, 419430}
			};
			pt_x = 0;
			pt_y = 0;
			mismatches = 0;
			last_row = 0;
			last_col = 0;
			foreach (plane_bits[i])
				plane_bits[i] = 1'b0;
		endfunction

		function longint clamp_q18(longint v);
			if (v > 64'sd8388607)
				return 64'sd8388607;
			if (v < -64'sd8388608)
				return -64'sd8388608;
			return v;
		endfunction

		function rsp_item_t predict_response(cmd_item_t c);
			rsp_item_t r;
			map_idx_t m;
			longint acc;
			longint nx;
			longint ny;
			longint col;
			longint row;
			r = '0;
			if (c.operation == OP_READ) begin
				if (c.read_row < PLANE_H && c.read_col < PLANE_W)
					r.pixel_bit = plane_bits[int'(c.read_row) * PLANE_W + int'(c.read_col)];
				return r;
			end
			if (c.random_pick < 1)
				m = MAP_STEM;
			else if (c.random_pick < 8)
				m = MAP_LEFT;
			else if (c.random_pick < 15)
				m = MAP_RIGHT;
			else
				m = MAP_MAIN;
			acc = pt_x * coefs[m][0] + pt_y * coefs[m][1];
			nx = clamp_q18(((acc + 64'sd131072) >>> 18) + coefs[m][2]);
			acc = pt_x * coefs[m][3] + pt_y * coefs[m][4];
			ny = clamp_q18(((acc + 64'sd131072) >>> 18) + coefs[m][5]);
			pt_x = nx;
			pt_y = ny;
			r.map_chosen = m;
			col = (longint'(PLANE_W) * (64'sd720896 + nx)) / 64'sd1441792;
			row = (longint'(PLANE_H) * (64'sd26476544 - 10 * ny)) / 64'sd26476544;
			if (col >= 0 && col < PLANE_W && row >= 0 && row < PLANE_H) begin
				plane_bits[row * PLANE_W + col] = 1'b1;
				r.plot_row = 8'(row);
				r.plot_col = 7'(col);
				r.plotted = 1'b1;
				last_row = int'(row);
				last_col = int'(col);
			end
			return r;
		endfunction

		function void note_command(cmd_item_t c);
			expected_rsp.push_back(predict_response(c));
		endfunction

		function void check_response(rsp_item_t got);
			rsp_item_t want;
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response: map %0d row %0d col %0d plotted %0b bit %0b",
						got.map_chosen, got.plot_row, got.plot_col, got.plotted, got.pixel_bit);
				return;
			end
			want = expected_rsp.pop_front();
			if (got.map_chosen !== want.map_chosen || got.plot_row !== want.plot_row ||
				got.plot_col !== want.plot_col || got.plotted !== want.plotted ||
				got.pixel_bit !== want.pixel_bit) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected map %0d row %0d col %0d plotted %0b bit %0b, got map %0d row %0d col %0d plotted %0b bit %0b",
						want.map_chosen, want.plot_row, want.plot_col, want.plotted, want.pixel_bit,
						got.map_chosen, got.plot_row, got.plot_col, got.plotted, got.pixel_bit);
			end
		endfunction

		function int pending();
			return expected_rsp.size();
		endfunction
	endclass

endpackage

[sim/tb.sv]
`timescale 1ns / 100ps
// Testbench top for the fern point plotter: stimulus, back-pressure and response checking.
module tb;
	import ifs_fern_pkg::*;
	import fern_plot_tb_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_item_t cmd;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_item_t rsp;
	bit        hold_req = 1'b0;

	fern_plot_scoreboard sb;

	ifs_fern_point_plotter_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	function automatic cmd_item_t iter_cmd(int pick);
		cmd_item_t c;
		c.operation = OP_ITERATE;
		c.random_pick = 7'(pick);
		c.read_row = 8'($urandom);
		c.read_col = 7'($urandom);
		return c;
	endfunction

	function automatic cmd_item_t read_cmd(int row, int col);
		cmd_item_t c;
		c.operation = OP_READ;
		c.random_pick = 7'($urandom);
		c.read_row = 8'(row);
		c.read_col = 7'(col);
		return c;
	endfunction

	function automatic cmd_item_t random_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return iter_cmd($urandom_range(0, 99));
		if (r < 85)
			return iter_cmd($urandom_range(100, 127));
		if (r < 92)
			return read_cmd(sb.last_row, sb.last_col);
		if (r < 96)
			return read_cmd($urandom_range(0, PLANE_H - 1), $urandom_range(0, PLANE_W - 1));
		return read_cmd($urandom_range(0, 255), $urandom_range(0, 127));
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send(input cmd_item_t c);
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic pause(input int n);
		if (n > 0) begin
			cmd_valid <= 1'b0;
			cmd <= random_cmd();
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending() > 0);
	endtask

	always @(posedge clk) begin
		if (cmd_valid && !cmd_stall)
			sb.note_command(cmd);
		if (rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	initial begin
		int mode;
		int left;
		int hold_left;
		rsp_stall = 1'b0;
		mode = 0;
		left = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 300;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 200);
			end
			left--;
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 3) == 0);
					2: rsp_stall <= ($urandom_range(0, 3) != 0);
					default: rsp_stall <= (left % 3 == 0);
				endcase
			end
		end
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int sent;
		int phase;
		sb = new();
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send(read_cmd(0, 0));
		send(read_cmd(PLANE_H - 1, PLANE_W - 1));
		send(read_cmd(PLANE_H, 0));
		send(read_cmd(255, 127));
		send(iter_cmd(0));
		send(iter_cmd(1));
		send(iter_cmd(7));
		send(iter_cmd(8));
		send(iter_cmd(14));
		send(iter_cmd(15));
		send(iter_cmd(99));
		send(read_cmd(sb.last_row, sb.last_col));
		send(iter_cmd(100));
		send(iter_cmd(127));
		send(read_cmd(sb.last_row, sb.last_col));
		send(iter_cmd(0));
		send(iter_cmd(50));
		send(iter_cmd(3));
		send(iter_cmd(10));
		send(read_cmd(sb.last_row, sb.last_col));
		send(read_cmd(PLANE_H - 1, 0));
		send(read_cmd(0, PLANE_W - 1));
		drain();

		sent = 0;
		phase = 0;
		while (sent < 2000) begin
			repeat ($urandom_range(1, 40)) begin
				send(random_cmd());
				sent++;
			end
			if (phase == 0 && sent >= 600) begin
				hold_req = 1'b1;
				phase = 1;
			end else if (phase == 1 && sent >= 1100) begin
				drain();
				phase = 2;
			end else if (phase == 2 && sent >= 1600) begin
				hold_req = 1'b1;
				phase = 3;
			end
			pause(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
		end
		drain();
		repeat (20) @(negedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
